[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/obdrc_pkg.sv]
// Types, constants, command table and reciprocal constants of the response decoder.
package obdrc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 37;
    localparam int NUM_W     = 24;
    localparam int MAG_W     = 23;
    localparam int K_W       = 4;
    localparam int REM_W     = 7;

    // Quotient reciprocal: exact floor for magnitudes below 2^MAG_W and divisors up to 125.
    localparam int RCP_S2 = 30;
    localparam int C2_W   = 28;
    // Fraction reciprocal: exact floor of rem * 2^(FRAC_BITS+1) / divisor.
    localparam int RCP_S3 = 14;
    localparam int C3_W   = FRAC_BITS + 13;
    localparam int FRC_W  = FRAC_BITS + 1;
    localparam int T_W    = MAG_W + FRAC_BITS + 2;
    localparam int CMP_W  = ((T_W > VAL_W) ? T_W : VAL_W) + 1;

    localparam int SCL_STAGES  = 6;
    localparam int PIPE_STAGES = SCL_STAGES + 1;

    localparam int MODE1_PIDS = 79;
    localparam int PID_IDX_W  = 7;

    localparam logic [7:0] MODE_CURRENT  = 8'h01;
    localparam logic [7:0] MODE_VEHINFO  = 8'h09;
    localparam logic [8:0] ECHO_OFFSET   = 9'h040;
    localparam logic [7:0] PID_SUPPORTED = 8'h00;
    localparam logic [7:0] PID_MSG_COUNT = 8'h01;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LEN     = 3'd1,
        ST_MODE    = 3'd2,
        ST_PID     = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_NUM  = 2'd1,
        KIND_BITS = 2'd2,
        KIND_O2   = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        FMT_NONE, FMT_B32, FMT_NOP, FMT_B16, FMT_PCT, FMT_TEMP, FMT_TRIM, FMT_FP,
        FMT_U8, FMT_RPM, FMT_TIM, FMT_MAF, FMT_B8, FMT_O2A, FMT_U16, FMT_RAIL,
        FMT_GAUGE, FMT_O2B, FMT_VAP, FMT_O2C, FMT_CAT, FMT_CMV, FMT_ABSL, FMT_FAE
    } t_fmt;

    // Odd part of the formula divisor; the power-of-two part is a shift.
    typedef enum logic [2:0] {
        DIV_1, DIV_5, DIV_25, DIV_51, DIV_125
    } t_div;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        t_div                    div;
        logic [K_W-1:0]          k;
    } t_term;

    typedef struct packed {
        t_status     status;
        t_kind       kind;
        logic [31:0] bits;
    } t_meta;

    typedef struct packed {
        t_meta meta;
        t_term pri;
        t_term sec;
    } t_dec;

    localparam t_fmt MODE1_FMT [MODE1_PIDS] = '{
        FMT_B32, FMT_B32, FMT_NOP, FMT_B16, FMT_PCT, FMT_TEMP, FMT_TRIM, FMT_TRIM,
        FMT_TRIM, FMT_TRIM, FMT_FP, FMT_U8, FMT_RPM, FMT_U8, FMT_TIM, FMT_TEMP,
        FMT_MAF, FMT_PCT, FMT_B8, FMT_B8, FMT_O2A, FMT_O2A, FMT_O2A, FMT_O2A,
        FMT_O2A, FMT_O2A, FMT_O2A, FMT_O2A, FMT_B8, FMT_B8, FMT_B8, FMT_U16,
        FMT_B32, FMT_U16, FMT_RAIL, FMT_GAUGE, FMT_O2B, FMT_O2B, FMT_O2B, FMT_O2B,
        FMT_O2B, FMT_O2B, FMT_O2B, FMT_O2B, FMT_PCT, FMT_TRIM, FMT_PCT, FMT_PCT,
        FMT_U8, FMT_U16, FMT_VAP, FMT_U8, FMT_O2C, FMT_O2C, FMT_O2C, FMT_O2C,
        FMT_O2C, FMT_O2C, FMT_O2C, FMT_O2C, FMT_CAT, FMT_CAT, FMT_CAT, FMT_CAT,
        FMT_B32, FMT_B32, FMT_CMV, FMT_ABSL, FMT_FAE, FMT_PCT, FMT_TEMP, FMT_PCT,
        FMT_PCT, FMT_PCT, FMT_PCT, FMT_PCT, FMT_PCT, FMT_U16, FMT_U16
    };

    localparam logic [C2_W-1:0] RCP_Q5   = C2_W'(((64'd1 << RCP_S2) + 64'd4) / 64'd5);
    localparam logic [C2_W-1:0] RCP_Q25  = C2_W'(((64'd1 << RCP_S2) + 64'd24) / 64'd25);
    localparam logic [C2_W-1:0] RCP_Q51  = C2_W'(((64'd1 << RCP_S2) + 64'd50) / 64'd51);
    localparam logic [C2_W-1:0] RCP_Q125 = C2_W'(((64'd1 << RCP_S2) + 64'd124) / 64'd125);

    localparam logic [C3_W-1:0] RCP_F5 =
        C3_W'(((64'd1 << (FRAC_BITS + 1 + RCP_S3)) + 64'd4) / 64'd5);
    localparam logic [C3_W-1:0] RCP_F25 =
        C3_W'(((64'd1 << (FRAC_BITS + 1 + RCP_S3)) + 64'd24) / 64'd25);
    localparam logic [C3_W-1:0] RCP_F51 =
        C3_W'(((64'd1 << (FRAC_BITS + 1 + RCP_S3)) + 64'd50) / 64'd51);
    localparam logic [C3_W-1:0] RCP_F125 =
        C3_W'(((64'd1 << (FRAC_BITS + 1 + RCP_S3)) + 64'd124) / 64'd125);

    function automatic logic [3:0] fmt_len(input t_fmt fmt);
        logic [3:0] len;
        case (fmt)
            FMT_B32, FMT_O2B, FMT_O2C:                       len = 4'd6;
            FMT_NONE, FMT_PCT, FMT_TEMP, FMT_TRIM, FMT_FP,
            FMT_U8, FMT_TIM, FMT_B8:                         len = 4'd3;
            default:                                         len = 4'd4;
        endcase
        return len;
    endfunction

    function automatic logic [REM_W-1:0] div_const(input t_div div);
        logic [REM_W-1:0] d;
        case (div)
            DIV_5:   d = 7'd5;
            DIV_25:  d = 7'd25;
            DIV_51:  d = 7'd51;
            DIV_125: d = 7'd125;
            default: d = 7'd1;
        endcase
        return d;
    endfunction

    function automatic logic [C2_W-1:0] rcp_quot(input t_div div);
        logic [C2_W-1:0] c;
        case (div)
            DIV_5:   c = RCP_Q5;
            DIV_25:  c = RCP_Q25;
            DIV_51:  c = RCP_Q51;
            DIV_125: c = RCP_Q125;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [C3_W-1:0] rcp_frac(input t_div div);
        logic [C3_W-1:0] c;
        case (div)
            DIV_5:   c = RCP_F5;
            DIV_25:  c = RCP_F25;
            DIV_51:  c = RCP_F51;
            DIV_125: c = RCP_F125;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[design/obd2_response_check_decode.sv]
// Top level of the diagnostic response checker and decoder.
//
//  channel  | dir | tdata (low bit up)                                | tuser
//  ---------+-----+---------------------------------------------------+------------------
//  s_axis   | in  | resp_length, echo_mode, echo_pid, data_a..data_d  | req_mode, req_pid
//  m_axis   | out | primary_value, secondary_value, bit_value         | status, value_kind
//
// One request enters per cycle while the output is not stalled; its result passes a decode stage
// and six stages of the fixed-point scaler (sign and magnitude, reciprocal quotient, remainder,
// fraction, rounding add, shift with saturation).
// Reset clears only the stage valid bits.
// Each stage is ready when empty or when the stage after it moves, so a stalled output
// holds its result while empty stages upstream keep taking requests.
`include "assert_macros.svh"

module obd2_response_check_decode
    import obdrc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // resp_length[3:0], echo_mode[11:4], echo_pid[19:12], data_a[27:20],
    // data_b[35:28], data_c[43:36], data_d[51:44], zero pad[55:52]
    input  logic [55:0]  i_s_axis_tdata,
    // req_mode[7:0], req_pid[15:8]
    input  logic [15:0]  i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // primary_value[36:0], secondary_value[73:37], bit_value[105:74], zero pad[111:106]
    output logic [111:0] o_m_axis_tdata,
    // status[2:0], value_kind[4:3]
    output logic [4:0]   o_m_axis_tuser
);

    localparam int LAST = PIPE_STAGES - 1;

    t_dec                    w_dec;
    t_dec                    r_dec;
    t_meta                   r_meta [PIPE_STAGES];
    logic [PIPE_STAGES-1:0]  r_vld, n_vld;
    logic [PIPE_STAGES-1:0]  w_rdy;
    logic signed [VAL_W-1:0] w_pv;
    logic signed [VAL_W-1:0] w_sv;

    obdrc_decode u_decode (
        .i_req_mode    (i_s_axis_tuser[7:0]),
        .i_req_pid     (i_s_axis_tuser[15:8]),
        .i_resp_length (i_s_axis_tdata[3:0]),
        .i_echo_mode   (i_s_axis_tdata[11:4]),
        .i_echo_pid    (i_s_axis_tdata[19:12]),
        .i_data_a      (i_s_axis_tdata[27:20]),
        .i_data_b      (i_s_axis_tdata[35:28]),
        .i_data_c      (i_s_axis_tdata[43:36]),
        .i_data_d      (i_s_axis_tdata[51:44]),
        .o_dec         (w_dec)
    );

    // Ready ripples back from the output register.
    always_comb begin
        w_rdy[LAST] = !r_vld[LAST] || i_m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_s_axis_tvalid;
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (w_rdy[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Advance payload with its stage; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dec     <= w_dec;
            r_meta[0] <= w_dec.meta;
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (w_rdy[i]) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    obdrc_scale u_scale_pri (
        .i_clk   (i_clk),
        .i_ld    (w_rdy[PIPE_STAGES-1:1]),
        .i_term  (r_dec.pri),
        .o_value (w_pv)
    );

    obdrc_scale u_scale_sec (
        .i_clk   (i_clk),
        .i_ld    (w_rdy[PIPE_STAGES-1:1]),
        .i_term  (r_dec.sec),
        .o_value (w_sv)
    );

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = {6'd0, r_meta[LAST].bits, w_sv, w_pv};
    assign o_m_axis_tuser  = {r_meta[LAST].kind, r_meta[LAST].status};

    `ASSERT_NEXT(a_accept_enters, i_s_axis_tvalid && o_s_axis_tready, r_vld[0], "accepted request did not enter decode stage")
    `ASSERT_IMPLIES(a_full_blocks, (&r_vld) && !i_m_axis_tready, !o_s_axis_tready, "ready high with a full stalled pipeline")
    `ASSERT_IMPLIES(a_fail_no_kind, o_m_axis_tvalid && (r_meta[LAST].status != ST_OK), (r_meta[LAST].kind == KIND_NONE) && (r_meta[LAST].bits == 32'd0), "failed check carries a value")
    `ASSERT_IMPLIES(a_none_zero, o_m_axis_tvalid && (r_meta[LAST].kind == KIND_NONE), (w_pv == '0) && (w_sv == '0), "empty result with nonzero scaled values")

endmodule

[design/obdrc_decode.sv]
// Command lookup, response checks and formula setup for one response.
module obdrc_decode
    import obdrc_pkg::*;
(
    input  logic [7:0] i_req_mode,
    input  logic [7:0] i_req_pid,
    input  logic [3:0] i_resp_length,
    input  logic [7:0] i_echo_mode,
    input  logic [7:0] i_echo_pid,
    input  logic [7:0] i_data_a,
    input  logic [7:0] i_data_b,
    input  logic [7:0] i_data_c,
    input  logic [7:0] i_data_d,
    output t_dec       o_dec
);

    logic                    known;
    t_fmt                    fmt;
    t_status                 status;
    logic signed [NUM_W-1:0] xa;
    logic signed [NUM_W-1:0] xb;
    logic signed [NUM_W-1:0] xab;
    logic signed [NUM_W-1:0] xcd;
    logic signed [NUM_W-1:0] xsab;

    assign xa   = NUM_W'(i_data_a);
    assign xb   = NUM_W'(i_data_b);
    assign xab  = NUM_W'({i_data_a, i_data_b});
    assign xcd  = NUM_W'({i_data_c, i_data_d});
    assign xsab = {{(NUM_W-16){i_data_a[7]}}, i_data_a, i_data_b};

    always_comb begin
        known = 1'b0;
        fmt   = FMT_NONE;
        if (i_req_mode == MODE_CURRENT && i_req_pid < 8'(MODE1_PIDS)) begin
            known = 1'b1;
            fmt   = MODE1_FMT[i_req_pid[PID_IDX_W-1:0]];
        end else if (i_req_mode == MODE_VEHINFO && i_req_pid == PID_SUPPORTED) begin
            known = 1'b1;
            fmt   = FMT_B32;
        end else if (i_req_mode == MODE_VEHINFO && i_req_pid == PID_MSG_COUNT) begin
            known = 1'b1;
            fmt   = FMT_NONE;
        end
    end

    // First failing check sets the status.
    always_comb begin
        if (!known) begin
            status = ST_UNKNOWN;
        end else if (i_resp_length != fmt_len(fmt)) begin
            status = ST_LEN;
        end else if ({1'b0, i_echo_mode} != ({1'b0, i_req_mode} + ECHO_OFFSET)) begin
            status = ST_MODE;
        end else if (i_echo_pid != i_req_pid) begin
            status = ST_PID;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_dec.meta.status = status;
        o_dec.meta.kind   = KIND_NONE;
        o_dec.meta.bits   = 32'd0;
        o_dec.pri.num     = '0;
        o_dec.pri.div     = DIV_1;
        o_dec.pri.k       = '0;
        o_dec.sec.num     = '0;
        o_dec.sec.div     = DIV_1;
        o_dec.sec.k       = '0;
        if (status == ST_OK) begin
            o_dec.meta.kind = KIND_NUM;
            case (fmt)
                FMT_B32: begin
                    o_dec.meta.kind = KIND_BITS;
                    o_dec.meta.bits = {i_data_a, i_data_b, i_data_c, i_data_d};
                end
                FMT_B16: begin
                    o_dec.meta.kind = KIND_BITS;
                    o_dec.meta.bits = {16'd0, i_data_a, i_data_b};
                end
                FMT_B8: begin
                    o_dec.meta.kind = KIND_BITS;
                    o_dec.meta.bits = {24'd0, i_data_a};
                end
                FMT_PCT: begin
                    o_dec.pri.num = xa * 24'sd20;
                    o_dec.pri.div = DIV_51;
                end
                FMT_TEMP: o_dec.pri.num = xa - 24'sd40;
                FMT_TRIM: begin
                    o_dec.pri.num = xa * 24'sd25 - 24'sd3200;
                    o_dec.pri.k   = 4'd5;
                end
                FMT_FP:    o_dec.pri.num = xa * 24'sd3;
                FMT_U8:    o_dec.pri.num = xa;
                FMT_RPM: begin
                    o_dec.pri.num = xab;
                    o_dec.pri.k   = 4'd2;
                end
                FMT_TIM: begin
                    o_dec.pri.num = xa - 24'sd128;
                    o_dec.pri.k   = 4'd1;
                end
                FMT_MAF: begin
                    o_dec.pri.num = xab;
                    o_dec.pri.div = DIV_25;
                    o_dec.pri.k   = 4'd2;
                end
                FMT_U16:   o_dec.pri.num = xab;
                FMT_RAIL: begin
                    o_dec.pri.num = xab * 24'sd79;
                    o_dec.pri.div = DIV_125;
                    o_dec.pri.k   = 4'd3;
                end
                FMT_GAUGE: o_dec.pri.num = xab * 24'sd10;
                FMT_VAP: begin
                    o_dec.pri.num = xsab;
                    o_dec.pri.k   = 4'd2;
                end
                FMT_CAT: begin
                    o_dec.pri.num = xab - 24'sd400;
                    o_dec.pri.div = DIV_5;
                    o_dec.pri.k   = 4'd1;
                end
                FMT_CMV: begin
                    o_dec.pri.num = xab;
                    o_dec.pri.div = DIV_125;
                    o_dec.pri.k   = 4'd3;
                end
                FMT_ABSL: begin
                    o_dec.pri.num = xab * 24'sd20;
                    o_dec.pri.div = DIV_51;
                end
                FMT_FAE: begin
                    o_dec.pri.num = xab;
                    o_dec.pri.k   = 4'd15;
                end
                FMT_O2A: begin
                    o_dec.meta.kind = KIND_O2;
                    o_dec.pri.num   = xa;
                    o_dec.pri.div   = DIV_25;
                    o_dec.pri.k     = 4'd3;
                    o_dec.sec.num   = xb * 24'sd25 - 24'sd3200;
                    o_dec.sec.k     = 4'd5;
                end
                FMT_O2B: begin
                    o_dec.meta.kind = KIND_O2;
                    o_dec.pri.num   = xcd;
                    o_dec.pri.k     = 4'd13;
                    o_dec.sec.num   = xab;
                    o_dec.sec.k     = 4'd15;
                end
                FMT_O2C: begin
                    o_dec.meta.kind = KIND_O2;
                    o_dec.pri.num   = xab;
                    o_dec.pri.k     = 4'd15;
                    o_dec.sec.num   = xcd - 24'sd32768;
                    o_dec.sec.k     = 4'd8;
                end
                default: o_dec.meta.kind = KIND_NONE;
            endcase
        end
    end

endmodule

[design/obdrc_scale.sv]
// Six-stage fixed-point scaler: round(num * 2^FRAC_BITS / (div * 2^k)), saturated.
module obdrc_scale
    import obdrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic [SCL_STAGES-1:0]   i_ld,
    input  t_term                   i_term,
    output logic signed [VAL_W-1:0] o_value
);

    localparam logic [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // stage A: sign and magnitude
    logic             r_a_neg, n_a_neg;
    logic [MAG_W-1:0] r_a_mag, n_a_mag;
    t_div             r_a_div;
    logic [K_W-1:0]   r_a_k;
    // stage B: quotient by the odd divisor
    logic             r_b_neg;
    logic [MAG_W-1:0] r_b_mag;
    logic [MAG_W-1:0] r_b_qd, n_b_qd;
    t_div             r_b_div;
    logic [K_W-1:0]   r_b_k;
    // stage C: remainder
    logic             r_c_neg;
    logic [MAG_W-1:0] r_c_qd;
    logic [REM_W-1:0] r_c_rem, n_c_rem;
    t_div             r_c_div;
    logic [K_W-1:0]   r_c_k;
    // stage D: fraction bits of rem / divisor
    logic             r_d_neg;
    logic [MAG_W-1:0] r_d_qd;
    logic [FRC_W-1:0] r_d_frc, n_d_frc;
    logic [K_W-1:0]   r_d_k;
    // stage E: rounded numerator before the shift
    logic             r_e_neg;
    logic [T_W-1:0]   r_e_t, n_e_t;
    logic [K_W-1:0]   r_e_k;
    // stage F: result
    logic [VAL_W-1:0] r_f_val, n_f_val;

    logic [MAG_W+C2_W-1:0]  quot_prod;
    logic [MAG_W-1:0]       qd_times_d;
    logic [MAG_W-1:0]       rem_full;
    logic [REM_W+C3_W-1:0]  frac_prod;
    logic [T_W-1:0]         shifted;
    logic [CMP_W-1:0]       mag_q;

    always_comb begin
        n_a_neg = i_term.num[NUM_W-1];
        n_a_mag = MAG_W'(n_a_neg ? -i_term.num : i_term.num);
    end

    always_comb begin
        quot_prod = (MAG_W+C2_W)'(r_a_mag) * (MAG_W+C2_W)'(rcp_quot(r_a_div));
        n_b_qd    = (r_a_div == DIV_1) ? r_a_mag
                                       : MAG_W'(quot_prod[MAG_W+C2_W-1:RCP_S2]);
    end

    always_comb begin
        qd_times_d = MAG_W'(r_b_qd * MAG_W'(div_const(r_b_div)));
        rem_full   = r_b_mag - qd_times_d;
        n_c_rem    = rem_full[REM_W-1:0];
    end

    always_comb begin
        frac_prod = (REM_W+C3_W)'(r_c_rem) * (REM_W+C3_W)'(rcp_frac(r_c_div));
        n_d_frc   = frac_prod[RCP_S3 +: FRC_W];
    end

    // Half of the divisor in the doubled scale, so the shift rounds half away.
    always_comb begin
        n_e_t = (T_W'(r_d_qd) << (FRAC_BITS + 1)) + (T_W'(1) << r_d_k) + T_W'(r_d_frc);
    end

    always_comb begin
        shifted = r_e_t >> ({1'b0, r_e_k} + 5'd1);
        mag_q   = CMP_W'(shifted);
        if (!r_e_neg) begin
            n_f_val = (mag_q > CMP_W'(SAT_POS)) ? SAT_POS : VAL_W'(mag_q);
        end else begin
            n_f_val = (mag_q > CMP_W'(SAT_NEG)) ? SAT_NEG : VAL_W'(~mag_q + CMP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_a_neg <= n_a_neg;
            r_a_mag <= n_a_mag;
            r_a_div <= i_term.div;
            r_a_k   <= i_term.k;
        end
        if (i_ld[1]) begin
            r_b_neg <= r_a_neg;
            r_b_mag <= r_a_mag;
            r_b_qd  <= n_b_qd;
            r_b_div <= r_a_div;
            r_b_k   <= r_a_k;
        end
        if (i_ld[2]) begin
            r_c_neg <= r_b_neg;
            r_c_qd  <= r_b_qd;
            r_c_rem <= n_c_rem;
            r_c_div <= r_b_div;
            r_c_k   <= r_b_k;
        end
        if (i_ld[3]) begin
            r_d_neg <= r_c_neg;
            r_d_qd  <= r_c_qd;
            r_d_frc <= n_d_frc;
            r_d_k   <= r_c_k;
        end
        if (i_ld[4]) begin
            r_e_neg <= r_d_neg;
            r_e_t   <= n_e_t;
            r_e_k   <= r_d_k;
        end
        if (i_ld[5]) begin
            r_f_val <= n_f_val;
        end
    end

    assign o_value = signed'(r_f_val);

endmodule
